### design/pwlg_pkg.sv
package pwlg_pkg;

  // table depth default and register map
  localparam int MaxPointsDef = 16;
  localparam int CountW       = 5;
  localparam int PaddrW       = 3;
  localparam int RegPointCount = 0;
  localparam logic [CountW-1:0] CountReset = CountW'(1);

  // divider: one quotient bit per step
  localparam int DivSteps = 32;
  localparam int DivCntW  = 5;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               point_x_null;
    logic               point_y_null;
    logic signed [31:0] sample_x;
    logic               sample_null;
  } item_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               y_null;
  } result_t;

  // one stored breakpoint
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               x_null;
    logic               y_null;
  } entry_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_we;
    logic eval_start;
    logic scan_en;
    logic decide;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_step;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_div;
    logic div_done;
  } status_t;

endpackage

### design/pwlg_ctrl.sv
module pwlg_ctrl
  import pwlg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  op_e     op_i,
  input  status_t status_i,
  output logic    busy,
  output ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op_i == OP_EVAL)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.need_div ? ST_MUL_LO : ST_DONE;
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_DONE;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.load_we    = accept && (op_i == OP_LOAD);
    ctrl_o.eval_start = accept && (op_i == OP_EVAL);
    ctrl_o.scan_en    = (state_q == ST_SCAN);
    ctrl_o.decide     = (state_q == ST_CHECK);
    ctrl_o.mul_lo     = (state_q == ST_MUL_LO);
    ctrl_o.mul_hi     = (state_q == ST_MUL_HI);
    ctrl_o.sum        = (state_q == ST_SUM);
    ctrl_o.div_step   = (state_q == ST_DIV);
    ctrl_o.finish     = (state_q == ST_DONE);
  end

  // an accepted evaluate item starts the table scan
  a_eval_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_EVAL)) |=> (state_q == ST_SCAN))
    else $error("evaluate item did not start a scan");

  // a load item completes in its accept cycle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_LOAD)) |=> (state_q == ST_IDLE))
    else $error("load item made the block busy");

  // the divider runs until its last step
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.div_done) |=> (state_q == ST_DIV))
    else $error("divide left early");

endmodule

### design/pwlg_dp.sv
module pwlg_dp
  import pwlg_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  item_t             item_i,
  input  logic [CountW-1:0] point_count_i,
  output status_t           status_o,
  output logic              result_valid_o,
  output result_t           result_o
);

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int NumW = $clog2(MAX_POINTS + 1);
  localparam int CmpW = (NumW > CountW) ? NumW : CountW;

  // breakpoint table
  entry_t mem [MAX_POINTS];
  entry_t rdata_q;
  entry_t wentry;
  logic   wr_ok;

  // scan control
  logic [IdxW-1:0] cnt_q, pidx_q, last_q;
  logic            iss_done_q, rvld_q;
  logic            iss_active;
  logic [CmpW-1:0] pc_ext;
  logic [NumW-1:0] n_eff;

  // scan results
  logic signed [31:0] x_q;
  logic               null_q, found_q;
  logic signed [31:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [31:0] lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  logic               first_yn_q, prev_yn_q, lo_yn_q, hi_yn_q;

  // decision and arithmetic
  logic signed [31:0] base_q, base_d;
  logic               interp_q, interp_d, null_d;
  logic [31:0]        dx_q, span_q, mag_q;
  logic               neg_q;
  logic signed [32:0] dy;
  logic [32:0]        dy_abs;
  logic [15:0]        mul_b;
  logic [47:0]        mul_p, plo_q, phi_q;
  logic [63:0]        full;

  // divider
  logic [31:0]        rem_q, quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [32:0]        shifted, trial;

  // final sum
  logic signed [33:0] sum;
  logic signed [31:0] sat_val;
  result_t            res_q;
  logic               res_vld_q;

  // table write and registered read
  assign wr_ok  = ctrl_i.load_we && (32'(item_i.point_index) < 32'(MAX_POINTS));
  assign wentry = '{x: item_i.point_x, y: item_i.point_y,
                    x_null: item_i.point_x_null, y_null: item_i.point_y_null};

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[IdxW'(item_i.point_index)] <= wentry;
    end
    rdata_q <= mem[cnt_q];
  end

  // breakpoints in use, clamped to the table
  always_comb begin
    pc_ext = CmpW'(point_count_i);
    if (pc_ext == '0) begin
      n_eff = NumW'(1);
    end else if (pc_ext > CmpW'(MAX_POINTS)) begin
      n_eff = NumW'(MAX_POINTS);
    end else begin
      n_eff = NumW'(pc_ext);
    end
  end

  assign iss_active = ctrl_i.scan_en && !iss_done_q;

  // scan read sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pidx_q     <= '0;
      last_q     <= '0;
      iss_done_q <= 1'b0;
      rvld_q     <= 1'b0;
    end else begin
      rvld_q <= iss_active;
      if (ctrl_i.eval_start) begin
        cnt_q      <= '0;
        pidx_q     <= '0;
        last_q     <= IdxW'(n_eff - NumW'(1));
        iss_done_q <= 1'b0;
      end else begin
        if (iss_active) begin
          if (cnt_q == last_q) begin
            iss_done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        if (rvld_q) begin
          pidx_q <= pidx_q + IdxW'(1);
        end
      end
    end
  end

  // per-entry checks and segment capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval_start) begin
      x_q     <= item_i.sample_x;
      null_q  <= item_i.sample_null;
      found_q <= 1'b0;
    end else if (rvld_q) begin
      // null abscissa or abscissas not strictly increasing
      if (rdata_q.x_null || (pidx_q != '0 && (rdata_q.x <= prev_x_q))) begin
        null_q <= 1'b1;
      end
      if (pidx_q == '0) begin
        first_x_q  <= rdata_q.x;
        first_y_q  <= rdata_q.y;
        first_yn_q <= rdata_q.y_null;
      end
      if (pidx_q != '0 && !found_q && (x_q <= rdata_q.x)) begin
        found_q <= 1'b1;
        lo_x_q  <= prev_x_q;
        lo_y_q  <= prev_y_q;
        lo_yn_q <= prev_yn_q;
        hi_x_q  <= rdata_q.x;
        hi_y_q  <= rdata_q.y;
        hi_yn_q <= rdata_q.y_null;
      end
      prev_x_q  <= rdata_q.x;
      prev_y_q  <= rdata_q.y;
      prev_yn_q <= rdata_q.y_null;
    end else if (ctrl_i.decide) begin
      null_q <= null_d;
    end
  end

  // clamp or interpolate
  always_comb begin
    null_d   = null_q;
    interp_d = 1'b0;
    if (x_q <= first_x_q) begin
      base_d = first_y_q;
      null_d = null_q || first_yn_q;
    end else if (x_q >= prev_x_q) begin
      base_d = prev_y_q;
      null_d = null_q || prev_yn_q;
    end else begin
      base_d   = lo_y_q;
      interp_d = 1'b1;
      null_d   = null_q || lo_yn_q || hi_yn_q;
    end
  end

  assign dy     = {hi_y_q[31], hi_y_q} - {lo_y_q[31], lo_y_q};
  assign dy_abs = dy[32] ? 33'(-dy) : 33'(dy);

  // shared 32x16 multiplier, low half of the magnitude first, then the high half
  assign mul_b = ctrl_i.mul_hi ? mag_q[31:16] : mag_q[15:0];
  assign mul_p = 48'(dx_q) * 48'(mul_b);
  assign full  = 64'(plo_q) + {phi_q, 16'b0};

  // restoring divide step
  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.decide) begin
      base_q   <= base_d;
      interp_q <= interp_d;
      dx_q     <= 32'(x_q - lo_x_q);
      span_q   <= 32'(hi_x_q - lo_x_q);
      mag_q    <= dy_abs[31:0];
      neg_q    <= dy[32];
    end
    if (ctrl_i.mul_lo) begin
      plo_q <= mul_p;
    end
    if (ctrl_i.mul_hi) begin
      phi_q <= mul_p;
    end
    if (ctrl_i.sum) begin
      rem_q     <= full[63:32];
      quo_q     <= full[31:0];
      div_cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
      end else begin
        rem_q <= shifted[31:0];
      end
      quo_q     <= {quo_q[30:0], !trial[32]};
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  // signed add or subtract of quotient and saturation
  always_comb begin
    if (neg_q) begin
      sum = {{2{base_q[31]}}, base_q} - $signed({2'b00, quo_q});
    end else begin
      sum = {{2{base_q[31]}}, base_q} + $signed({2'b00, quo_q});
    end
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat_val = sum[31:0];
    end else if (sum[33]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7fff_ffff;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      res_q.y_null <= null_q;
      if (null_q) begin
        res_q.y_value <= '0;
      end else if (interp_q) begin
        res_q.y_value <= sat_val;
      end else begin
        res_q.y_value <= base_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= ctrl_i.finish;
    end
  end

  assign result_valid_o     = res_vld_q;
  assign result_o           = res_q;
  assign status_o.scan_done = rvld_q && (pidx_q == last_q);
  assign status_o.need_div  = interp_d && !null_d;
  assign status_o.div_done  = ctrl_i.div_step && (div_cnt_q == DivCntW'(DivSteps - 1));

  // a result item follows each finish, and only then
  a_res_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(ctrl_i.finish))
    else $error("result item without a finished evaluation");

  // null results carry a zero value
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.y_null) |-> (res_q.y_value == '0))
    else $error("null result with nonzero value");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |-> (rem_q < span_q))
    else $error("divider remainder out of range");

endmodule

### design/piecewise_linear_graph_unit.sv
// Piecewise-linear graph unit. A load item (op = load) writes one breakpoint
// into the table in its accept cycle; busy stays low, so items may follow
// back to back. An evaluate item keeps busy high while it scans the table
// through its single registered read port, picks the segment, runs the 32x16
// multiplier over the low and then the high half, sums the halves, runs the
// divider that yields one quotient bit per cycle, and then saturates and
// registers the result. When the result is null or clamped to an end
// breakpoint the multiply and divide are skipped. The result item shows on
// result_o for exactly one cycle with result_valid_o high, the cycle busy
// drops; the receiver cannot stall it, and a new item may be started in that
// same cycle. point_count must be written over the APB port only while the
// block is idle; the block itself does not enforce this.
module piecewise_linear_graph_unit
  import pwlg_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              result_valid_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CountW-1:0] point_count_q;
  logic              reg_sel;
  ctrl_t             ctrl;
  status_t           status;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (32'(paddr[PaddrW-1:2]) == 32'(RegPointCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CountReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      point_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(point_count_q) : '0;

  // sequencer
  pwlg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (item_i.op),
    .status_i (status),
    .busy     (busy),
    .ctrl_o   (ctrl)
  );

  // table, scan and arithmetic
  pwlg_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .item_i         (item_i),
    .point_count_i  (point_count_q),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### tb/tb.sv
module tb;
  import pwlg_pkg::*;

  localparam int NumPoints = MaxPointsDef;
  localparam logic [PaddrW-1:0] CountAddr    = PaddrW'(RegPointCount * 4);
  localparam logic [PaddrW-1:0] UnmappedAddr = PaddrW'((RegPointCount + 1) * 4);
  localparam int RandomItems = 1300;
  localparam int ErrorPrintCap = 50;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic              start   = 1'b0;
  item_t             item_drv = '0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;

  // block outputs
  logic        busy;
  logic        result_valid_o;
  result_t     result_o;
  logic [31:0] prdata;
  logic        pready;

  piecewise_linear_graph_unit #(
    .MAX_POINTS(NumPoints)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_drv),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow breakpoint table and count register
  logic signed [31:0] bp_x  [NumPoints];
  logic signed [31:0] bp_y  [NumPoints];
  logic               bp_xn [NumPoints];
  logic               bp_yn [NumPoints];
  logic [CountW-1:0]  point_count_q = CountReset;

  result_t pending_y_q [$];
  result_t y_want;
  int      mismatches = 0;
  logic    no_idle = 1'b0;

  // one line per mismatch, capped to keep the log short
  task automatic report_mismatch(string msg);
    if (mismatches < ErrorPrintCap) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  // linear interpolation of one sample over the shadow table
  function automatic result_t interpolate_sample(item_t it);
    result_t            r;
    int                 n;
    logic               is_null;
    longint             x, x0, x1, y0, y1, dy, res;
    logic [63:0]        dx, span, mag, quo;
    n = int'(point_count_q);
    if (n < 1) n = 1;
    if (n > NumPoints) n = NumPoints;
    x = 64'($signed(it.sample_x));
    res = 0;
    is_null = it.sample_null;
    for (int j = 0; j < n; j++) begin
      if (bp_xn[j]) is_null = 1'b1;
    end
    for (int j = 0; j + 1 < n; j++) begin
      if (bp_x[j+1] <= bp_x[j]) is_null = 1'b1;
    end
    if (!is_null) begin
      if (x <= 64'(bp_x[0])) begin
        if (bp_yn[0]) is_null = 1'b1;
        else res = 64'(bp_y[0]);
      end else if (x >= 64'(bp_x[n-1])) begin
        if (bp_yn[n-1]) is_null = 1'b1;
        else res = 64'(bp_y[n-1]);
      end else begin
        for (int j = 0; j + 1 < n; j++) begin
          if (x <= 64'(bp_x[j+1])) begin
            if (bp_yn[j] || bp_yn[j+1]) begin
              is_null = 1'b1;
            end else begin
              x0 = 64'(bp_x[j]);
              x1 = 64'(bp_x[j+1]);
              y0 = 64'(bp_y[j]);
              y1 = 64'(bp_y[j+1]);
              dx = x - x0;
              span = x1 - x0;
              dy = y1 - y0;
              mag = dx * ((dy < 0) ? -dy : dy);
              quo = (span != 0) ? mag / span : 64'd0;
              res = (dy < 0) ? y0 - $signed(quo) : y0 + $signed(quo);
              if (res > 64'sd2147483647) res = 64'sd2147483647;
              else if (res < -64'sd2147483648) res = -64'sd2147483648;
            end
            break;
          end
        end
      end
    end
    r.y_null  = is_null;
    r.y_value = is_null ? 32'sd0 : res[31:0];
    return r;
  endfunction

  // idle length after an item: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 90);
  endfunction

  // drive one item, wait for it to be taken, then update the shadow state
  task automatic send_item(item_t it);
    int gap;
    item_drv <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.op == OP_LOAD) begin
      bp_x[it.point_index]  = it.point_x;
      bp_y[it.point_index]  = it.point_y;
      bp_xn[it.point_index] = it.point_x_null;
      bp_yn[it.point_index] = it.point_y_null;
    end else begin
      pending_y_q.push_back(interpolate_sample(it));
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // fields the operation does not use stay random
  function automatic item_t random_item(op_e op);
    item_t it;
    it.op           = op;
    it.point_index  = 4'($urandom);
    it.point_x      = $urandom;
    it.point_y      = $urandom;
    it.point_x_null = 1'($urandom);
    it.point_y_null = 1'($urandom);
    it.sample_x     = $urandom;
    it.sample_null  = 1'($urandom);
    return it;
  endfunction

  task automatic load_point(int idx, logic signed [31:0] x, logic signed [31:0] y,
                            logic xn, logic yn);
    item_t it;
    it = random_item(OP_LOAD);
    it.point_index  = 4'(idx);
    it.point_x      = x;
    it.point_y      = y;
    it.point_x_null = xn;
    it.point_y_null = yn;
    send_item(it);
  endtask

  task automatic eval_sample(logic signed [31:0] x, logic sn);
    item_t it;
    it = random_item(OP_EVAL);
    it.sample_x    = x;
    it.sample_null = sn;
    send_item(it);
  endtask

  // stop sending and let the block settle before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_y_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  // apb write: setup, access, then idle
  task automatic apb_write(logic [PaddrW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == CountAddr) point_count_q = data[CountW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // apb read, checked against the shadow register
  task automatic apb_read_check(logic [PaddrW-1:0] addr);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    if (rd[CountW-1:0] !== point_count_q) begin
      report_mismatch($sformatf("point_count read %0d, want %0d",
                                rd[CountW-1:0], point_count_q));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_point_count(logic [CountW-1:0] cnt);
    logic [31:0] wdata;
    wait_idle();
    wdata = $urandom;
    wdata[CountW-1:0] = cnt;
    apb_write(CountAddr, wdata);
    apb_read_check(CountAddr);
  endtask

  // directed breakpoint grid: full x range, y swinging between extremes
  function automatic logic signed [31:0] grid_x(int i);
    if (i == 0) return 32'sh8000_0000;
    if (i == NumPoints - 1) return 32'sh7FFF_FFFF;
    return 32'((i - 7) * 32'sh0800_0000);
  endfunction

  function automatic logic signed [31:0] grid_y(int i);
    return (i % 2 == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // reset value and an unmapped address
  task automatic test_register_map();
    wait_idle();
    apb_read_check(CountAddr);
    apb_write(UnmappedAddr, 32'hFFFF_FFFF);
    apb_read_check(CountAddr);
  endtask

  // fill every slot so no later evaluation reads an unwritten one
  task automatic test_table_load();
    for (int i = 0; i < NumPoints; i++) begin
      load_point(i, grid_x(i), grid_y(i), 1'b0, 1'b0);
    end
  endtask

  // clamping at both ends, exact breakpoints, wide products
  task automatic test_clamp_interp();
    set_point_count(CountW'(NumPoints));
    eval_sample(32'sh8000_0000, 1'b0);
    eval_sample(32'sh7FFF_FFFF, 1'b0);
    eval_sample(32'sh0000_0000, 1'b0);
    eval_sample(32'sh0400_0000, 1'b0);
    eval_sample(grid_x(1) - 1, 1'b0);
    eval_sample(grid_x(14) + 1, 1'b0);
    set_point_count(CountW'(2));
    eval_sample(32'sh0000_0000, 1'b0);
    eval_sample(-32'sh4000_0000, 1'b0);
    set_point_count(CountW'(1));
    eval_sample(32'sh0000_0000, 1'b0);
  endtask

  // null sample, null x, null y used and unused, non-increasing x
  task automatic test_null_marks();
    set_point_count(CountW'(NumPoints));
    eval_sample(32'sh0000_1234, 1'b1);
    load_point(3, grid_x(3), grid_y(3), 1'b1, 1'b0);
    eval_sample(32'sh0000_0000, 1'b0);
    load_point(3, grid_x(3), grid_y(3), 1'b0, 1'b0);
    load_point(5, grid_x(5), grid_y(5), 1'b0, 1'b1);
    eval_sample(grid_x(4) + 1, 1'b0);
    eval_sample(grid_x(10) + 5, 1'b0);
    load_point(5, grid_x(5), grid_y(5), 1'b0, 1'b0);
    load_point(8, grid_x(7), grid_y(8), 1'b0, 1'b0);
    eval_sample(grid_x(12), 1'b0);
    load_point(8, grid_x(8), grid_y(8), 1'b0, 1'b0);
    load_point(0, grid_x(0), grid_y(0), 1'b0, 1'b1);
    eval_sample(32'sh8000_0000, 1'b0);
    eval_sample(32'sh7FFF_FFFF, 1'b0);
    load_point(0, grid_x(0), grid_y(0), 1'b0, 1'b0);
  endtask

  // count of zero acts as one, above the table depth as the full table
  task automatic test_count_limits();
    set_point_count(CountW'(0));
    eval_sample(32'sh0000_0005, 1'b0);
    set_point_count(CountW'(31));
    eval_sample(32'sh7FFF_FFFF, 1'b0);
    set_point_count(CountW'(NumPoints + 1));
    eval_sample(grid_x(3) + 7, 1'b0);
  endtask

  // random tables, mostly increasing, with samples aimed at the segments
  task automatic test_random_tables();
    int unsigned        pts [$];
    logic signed [31:0] xs [NumPoints];
    int                 order [NumPoints];
    int                 sent, n, k, j, tmp, sel, sh, evals, xn_slot, yn_slot, slot;
    logic [CountW-1:0]  cnt;
    logic [31:0]        mask, base, u0, u1;
    logic signed [31:0] sx;
    sent = 0;
    while (sent < RandomItems) begin
      // count for this table, extremes included
      sel = $urandom_range(0, 99);
      if (sel < 10) cnt = CountW'(1);
      else if (sel < 22) cnt = CountW'(NumPoints);
      else if (sel < 25) cnt = CountW'(0);
      else if (sel < 28) cnt = CountW'($urandom_range(NumPoints + 1, 31));
      else cnt = CountW'($urandom_range(2, NumPoints - 1));
      set_point_count(cnt);
      n = (cnt == '0) ? 1 : (int'(cnt) > NumPoints) ? NumPoints : int'(cnt);
      no_idle = ($urandom_range(0, 4) == 0);

      // sorted abscissas, clustered or spread over the whole range
      sh = $urandom_range(4, 32);
      mask = (sh >= 32) ? 32'hFFFF_FFFF : (32'h1 << sh) - 32'h1;
      base = $urandom_range(0, 32'hFFFF_FFFF - mask);
      pts.delete();
      for (k = 0; k < NumPoints; k++) pts.push_back(base + ($urandom & mask));
      pts.sort();
      for (k = 0; k < NumPoints; k++) xs[k] = pts[k] ^ 32'h8000_0000;
      if ($urandom_range(0, 99) < 10) begin
        k = $urandom_range(0, NumPoints - 2);
        xs[k+1] = $urandom_range(0, 1) ? xs[k] : xs[k] - 1;
      end
      xn_slot = ($urandom_range(0, 99) < 6) ? $urandom_range(0, n - 1) : -1;
      yn_slot = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n - 1) : -1;

      // load the used slots in shuffled order
      for (k = 0; k < n; k++) order[k] = k;
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (k = 0; k < n; k++) begin
        slot = order[k];
        load_point(slot, xs[slot], $urandom, slot == xn_slot, slot == yn_slot);
        sent++;
      end

      evals = $urandom_range(10, 30);
      for (k = 0; k < evals; k++) begin
        // occasional stray load in the middle of a run
        if ($urandom_range(0, 99) < 3) begin
          slot = $urandom_range(0, NumPoints - 1);
          load_point(slot, ($urandom_range(0, 99) < 70) ? xs[slot] : $urandom, $urandom,
                     $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 5);
          sent++;
        end
        sel = $urandom_range(0, 99);
        u0 = xs[0] ^ 32'h8000_0000;
        u1 = xs[n-1] ^ 32'h8000_0000;
        if (sel < 10) begin
          sx = $urandom;
        end else if (sel < 20) begin
          sx = $urandom_range(0, u0) ^ 32'h8000_0000;
        end else if (sel < 30) begin
          sx = $urandom_range(u1, 32'hFFFF_FFFF) ^ 32'h8000_0000;
        end else if (sel < 45) begin
          sx = xs[$urandom_range(0, n - 1)];
        end else begin
          j = (n > 1) ? $urandom_range(0, n - 2) : 0;
          u0 = xs[j] ^ 32'h8000_0000;
          u1 = xs[(n > 1) ? j + 1 : j] ^ 32'h8000_0000;
          sx = ((u1 >= u0) ? $urandom_range(u0, u1) : u0) ^ 32'h8000_0000;
        end
        eval_sample(sx, $urandom_range(0, 99) < 3);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // compare each result with the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_y_q.size() == 0) begin
        report_mismatch("result with no evaluate item pending");
      end else begin
        y_want = pending_y_q.pop_front();
        if (result_o.y_null !== y_want.y_null) begin
          report_mismatch($sformatf("y_null %b, want %b", result_o.y_null, y_want.y_null));
        end
        if (result_o.y_value !== y_want.y_value) begin
          report_mismatch($sformatf("y_value %h, want %h",
                                    result_o.y_value, y_want.y_value));
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_map();
    test_table_load();
    test_clamp_interp();
    test_null_marks();
    test_count_limits();
    test_random_tables();
    // drain, then allow one full evaluation of slack
    start <= 1'b0;
    while (pending_y_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (pending_y_q.size() == 0 && mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
